@@ design/fnv_pkg.sv @@
// Shared types and constants for the FNV-1a-style intern table (non-standard offset basis).
`default_nettype none
package fnv_pkg;
  localparam int TABLE_SLOTS = 4096;
  localparam int MAX_ENTRIES = 1024;
  localparam int KEY_BYTES = 32;
  localparam logic [63:0] FNV_PRIME = 64'd1099511628211;
  localparam logic [63:0] FNV_BASIS = 64'd1469598103934665603;
  localparam logic ACT_KEY = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_HMUL, ST_HSUM, ST_PAD, ST_SLOT_RD, ST_SLOT_CHK,
    ST_CMP_RD, ST_CMP_CHK, ST_INS, ST_OUT
  } fnv_state_t;

  typedef struct packed {
    logic clr_start;
    logic clr_step;
    logic key_take;
    logic hash_mul;
    logic hash_sum;
    logic pad_step;
    logic probe_init;
    logic probe_next;
    logic slot_rd;
    logic cmp_init;
    logic cmp_rd;
    logic cmp_next;
    logic ins_step;
    logic ins_slot;
    logic set_hit;
    logic set_fail;
  } fnv_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic pad_more;
    logic pos_full;
    logic slot_empty;
    logic slot_valid_id;
    logic store_full;
    logic probes_done;
    logic byte_eq;
    logic cmp_last;
    logic ins_last;
  } fnv_stat_t;
endpackage
`default_nettype wire

@@ design/fnv_if.sv @@
// Valid/ready channel interface carrying one payload beat.
`default_nettype none
interface fnv_if #(parameter int W = 8) (input wire logic clk);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/fnv_ctrl.sv @@
// Controller state machine of the FNV intern table.
`default_nettype none
module fnv_ctrl
  import fnv_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_action,
  input wire logic in_last,
  input wire logic out_free,
  input wire fnv_stat_t stat,
  output logic in_ready,
  output logic out_load,
  output fnv_cmd_t cmd
);
  fnv_state_t state, state_next;
  logic pend_last, pend_last_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      pend_last <= 1'b0;
    end else begin
      state <= state_next;
      pend_last <= pend_last_next;
    end
  end

  always_comb begin
    state_next = state;
    pend_last_next = pend_last;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_CLEAR) begin
            state_next = ST_CLEAR;
          end else if (!stat.pos_full) begin
            state_next = ST_HMUL;
            pend_last_next = in_last;
          end else if (in_last) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_CLEAR: if (stat.clr_done) state_next = ST_IDLE;
      ST_HMUL: state_next = ST_HSUM;
      ST_HSUM: state_next = pend_last ? ST_PAD : ST_IDLE;
      ST_PAD: begin
        if (stat.pad_more) state_next = ST_HMUL;
        else state_next = ST_SLOT_RD;
        pend_last_next = 1'b1;
      end
      ST_SLOT_RD: state_next = ST_SLOT_CHK;
      ST_SLOT_CHK: begin
        if (stat.slot_empty) state_next = stat.store_full ? ST_OUT : ST_INS;
        else if (stat.slot_valid_id) state_next = ST_CMP_RD;
        else if (stat.probes_done) state_next = ST_OUT;
        else state_next = ST_SLOT_RD;
      end
      ST_CMP_RD: state_next = ST_CMP_CHK;
      ST_CMP_CHK: begin
        if (!stat.byte_eq) state_next = stat.probes_done ? ST_OUT : ST_SLOT_RD;
        else if (stat.cmp_last) state_next = ST_OUT;
        else state_next = ST_CMP_RD;
      end
      ST_INS: if (stat.ins_last) state_next = ST_OUT;
      ST_OUT: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == ACT_CLEAR) cmd.clr_start = 1'b1;
          else if (!stat.pos_full) cmd.key_take = 1'b1;
        end
      end
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_HMUL: cmd.hash_mul = 1'b1;
      ST_HSUM: cmd.hash_sum = 1'b1;
      ST_PAD: begin
        if (stat.pad_more) cmd.pad_step = 1'b1;
        else cmd.probe_init = 1'b1;
      end
      ST_SLOT_RD: cmd.slot_rd = 1'b1;
      ST_SLOT_CHK: begin
        if (stat.slot_empty) begin
          if (stat.store_full) cmd.set_fail = 1'b1;
        end else if (stat.slot_valid_id) begin
          cmd.cmp_init = 1'b1;
        end else if (stat.probes_done) begin
          cmd.set_fail = 1'b1;
        end else begin
          cmd.probe_next = 1'b1;
        end
      end
      ST_CMP_RD: cmd.cmp_rd = 1'b1;
      ST_CMP_CHK: begin
        if (!stat.byte_eq) begin
          if (stat.probes_done) cmd.set_fail = 1'b1;
          else cmd.probe_next = 1'b1;
        end else if (stat.cmp_last) begin
          cmd.set_hit = 1'b1;
        end else begin
          cmd.cmp_next = 1'b1;
        end
      end
      ST_INS: begin
        cmd.ins_step = 1'b1;
        if (stat.ins_last) cmd.ins_slot = 1'b1;
      end
      ST_OUT: out_load = out_free;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

@@ design/fnv_dp.sv @@
// Datapath of the FNV intern table: hash, key buffer, slot table and key store.
`default_nettype none
module fnv_dp
  import fnv_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic [7:0] in_byte,
  input wire fnv_cmd_t cmd,
  output fnv_stat_t stat,
  output logic [9:0] res_id,
  output logic res_new,
  output logic res_fail
);
  localparam int SW = $clog2(TABLE_SLOTS);
  localparam int PW = $clog2(TABLE_SLOTS + 1);
  localparam int EW = $clog2(MAX_ENTRIES + 1);
  localparam int KW = $clog2(KEY_BYTES + 1);
  localparam int KI = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int SD = 1 << SW;

  logic [63:0] hash, hx;
  logic [63:0] p0, p1, p2, p3;
  logic [KW-1:0] pos;
  logic [7:0] cur_byte;
  logic [7:0] key_buf [KEY_BYTES];
  logic [EW-1:0] slot_mem [SD];
  logic [7:0] store_mem [MAX_ENTRIES * KEY_BYTES];
  logic [SW-1:0] index, clr_addr;
  logic [PW-1:0] probes;
  logic [EW-1:0] slot_q, count;
  logic [KW-1:0] bidx;
  logic [7:0] store_q;
  logic [IW-1:0] cmp_id;
  logic [KI-1:0] bsel;

  assign bsel = bidx[KI-1:0];

  always_ff @(posedge clk) begin
    if (cmd.key_take || cmd.pad_step) begin
      cur_byte <= cmd.pad_step ? 8'd0 : in_byte;
      key_buf[pos[KI-1:0]] <= cmd.pad_step ? 8'd0 : in_byte;
    end
  end

  // Hash multiply split into four 64x16 partial products.
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start || cmd.probe_init) begin
      hash <= FNV_BASIS;
    end else if (cmd.hash_sum) begin
      hash <= p0 + (p1 << 16) + (p2 << 32) + (p3 << 48);
    end
  end
  assign hx = hash ^ {56'd0, cur_byte};
  always_ff @(posedge clk) begin
    if (cmd.hash_mul) begin
      p0 <= hx * {48'd0, FNV_PRIME[15:0]};
      p1 <= hx * {48'd0, FNV_PRIME[31:16]};
      p2 <= hx * {48'd0, FNV_PRIME[47:32]};
      p3 <= hx * {48'd0, FNV_PRIME[63:48]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start || cmd.probe_init) pos <= '0;
    else if (cmd.key_take || cmd.pad_step) pos <= pos + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) clr_addr <= '0;
    else if (cmd.clr_step) clr_addr <= clr_addr + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) count <= '0;
    else if (cmd.ins_slot) count <= count + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.probe_init) begin
      index <= hash[SW-1:0];
      probes <= '0;
    end else if (cmd.probe_next) begin
      index <= index + 1'b1;
      probes <= probes + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) slot_mem[clr_addr] <= '0;
    else if (cmd.ins_slot) slot_mem[index] <= count + 1'b1;
    if (cmd.slot_rd) slot_q <= slot_mem[index];
  end

  assign cmp_id = IW'(slot_q - 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.cmp_init || cmd.set_hit || cmd.probe_next || cmd.probe_init) bidx <= '0;
    else if (cmd.cmp_next || cmd.ins_step) bidx <= bidx + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_step) store_mem[{count[IW-1:0], bsel}] <= key_buf[bsel];
    if (cmd.cmp_rd) store_q <= store_mem[{cmp_id, bsel}];
  end

  always_ff @(posedge clk) begin
    if (cmd.probe_init) begin
      res_id <= '0;
      res_new <= 1'b0;
      res_fail <= 1'b0;
    end else if (cmd.set_fail) begin
      res_fail <= 1'b1;
    end else if (cmd.set_hit) begin
      res_id <= 10'(cmp_id);
    end else if (cmd.ins_slot) begin
      res_id <= 10'(count);
      res_new <= 1'b1;
    end
  end

  assign stat.clr_done = (clr_addr == SW'(SD - 1));
  assign stat.pad_more = (pos < KW'(KEY_BYTES));
  assign stat.pos_full = (pos == KW'(KEY_BYTES));
  assign stat.slot_empty = (slot_q == '0);
  assign stat.slot_valid_id = (slot_q <= EW'(MAX_ENTRIES));
  assign stat.store_full = (count >= EW'(MAX_ENTRIES));
  assign stat.probes_done = (probes == PW'(TABLE_SLOTS - 1));
  assign stat.byte_eq = (store_q == key_buf[bsel]);
  assign stat.cmp_last = (bidx == KW'(KEY_BYTES - 1));
  assign stat.ins_last = (bidx == KW'(KEY_BYTES - 1));
endmodule
`default_nettype wire

@@ design/fnv_linear_probe_intern_table.sv @@
// Top level of the FNV-1a-style linear-probing intern table.
// Key bytes arrive on in_ch (action, key_byte, last_byte), one per beat.
// A key byte is accepted, multiplied in four partial products, then
// summed into the 64-bit running hash. On the last byte, missing bytes
// are padded with zeros the same way, then the slot table is probed:
// each slot is read and checked, each compared key byte is read and
// checked, and a new key is copied byte by byte into the key store.
// One result beat (entry_id, is_new, failed) leaves on out_ch per key,
// held in an output register until the receiver takes it; a stalled
// receiver holds the block in its output state.
// A clear beat sweeps the slot table, one slot per cycle, and gives
// no result. After reset the same sweep runs before the first beat
// is accepted. The key store needs no clearing.
`default_nettype none
module fnv_linear_probe_intern_table
  import fnv_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  fnv_if.sink in_ch,
  fnv_if.source out_ch
);
  fnv_cmd_t cmd;
  fnv_stat_t stat;
  logic out_load, in_ready;
  logic [9:0] res_id;
  logic res_new, res_fail;
  logic ov;
  logic [11:0] od;

  assign in_ch.ready = in_ready;

  fnv_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_action(in_ch.data[0]),
    .in_last(in_ch.data[9]), .out_free(!ov || out_ch.ready), .stat(stat),
    .in_ready(in_ready), .out_load(out_load), .cmd(cmd)
  );

  fnv_dp u_dp (
    .clk(clk), .rst(rst), .in_byte(in_ch.data[8:1]), .cmd(cmd), .stat(stat),
    .res_id(res_id), .res_new(res_new), .res_fail(res_fail)
  );

  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else if (out_load) ov <= 1'b1;
    else if (out_ch.ready) ov <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (out_load) od <= {res_fail, res_new, res_id};
  end
  assign out_ch.valid = ov;
  assign out_ch.data = od;
endmodule
`default_nettype wire
